### rtl/vts_pkg.sv
package vts_pkg;

	// Field widths of the request and result channels.
	localparam int CHAR_W    = 8;
	localparam int CMD_W     = 2;
	localparam int LIMIT_W   = 10;
	localparam int GAIN_W    = 4;
	localparam int HELD_W    = 11;
	localparam int DEC_W     = 16;
	localparam int SMOOTH_W  = 16;
	localparam int STEER_W   = 32;
	localparam int TURRET_W  = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	// Window depth default and value bounds used to size the datapath.
	localparam int WINDOW_DEF = 20;
	localparam int HELD_MAX   = 999;
	localparam int GAIN_MAX   = 2 ** GAIN_W - 1;
	localparam int MEAN_SCALE = 20;

	// ASCII codes of the frame.
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;

	// Reset values of the configuration registers and the turret angle.
	localparam logic [LIMIT_W-1:0]  X_REJECT_RST = 10'd300;
	localparam logic [LIMIT_W-1:0]  X_CLAMP_RST  = 10'd100;
	localparam logic [LIMIT_W-1:0]  Y_REJECT_RST = 10'd200;
	localparam logic [LIMIT_W-1:0]  Y_CLAMP_RST  = 10'd50;
	localparam logic [GAIN_W-1:0]   GAIN_RST     = 4'd3;
	localparam logic [TURRET_W-1:0] TURRET_LOW_RST  = 16'd2000;
	localparam logic [TURRET_W-1:0] TURRET_HIGH_RST = 16'd10000;
	localparam logic [TURRET_W-1:0] TURRET_RST      = 16'd6000;

	typedef enum logic [CMD_W-1:0] {
		CMD_HOLD = 2'd0,
		CMD_GET  = 2'd1,
		CMD_NONE = 2'd2,
		CMD_LOCK = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_REJECT   = 3'd0,
		REG_X_CLAMP    = 3'd1,
		REG_Y_REJECT   = 3'd2,
		REG_Y_CLAMP    = 3'd3,
		REG_STEER_GAIN = 3'd4,
		REG_TURRET_LOW = 3'd5,
		REG_TURRET_HIGH = 3'd6
	} cfg_reg_t;

	typedef logic signed [HELD_W-1:0]   held_t;
	typedef logic signed [SMOOTH_W-1:0] smooth_t;

	// Result of the mean stages handed to the steering stage.
	typedef struct packed {
		held_t   held_x;
		held_t   held_y;
		smooth_t smooth_x;
		smooth_t smooth_y;
	} mean_t;

endpackage

### rtl/vts_track.sv
module vts_track #(
	parameter int WINDOW = vts_pkg::WINDOW_DEF,
	localparam int SUM_W = $clog2(WINDOW * vts_pkg::HELD_MAX + 1) + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [vts_pkg::CMD_W-1:0]     command,
	input  logic [vts_pkg::CHAR_W-1:0]    x_sign_char,
	input  logic [vts_pkg::CHAR_W-1:0]    x_tens_char,
	input  logic [vts_pkg::CHAR_W-1:0]    x_ones_char,
	input  logic [vts_pkg::CHAR_W-1:0]    x_tenths_char,
	input  logic [vts_pkg::CHAR_W-1:0]    y_sign_char,
	input  logic [vts_pkg::CHAR_W-1:0]    y_tens_char,
	input  logic [vts_pkg::CHAR_W-1:0]    y_ones_char,
	input  logic [vts_pkg::CHAR_W-1:0]    y_tenths_char,
	input  logic [vts_pkg::LIMIT_W-1:0]   x_reject_limit,
	input  logic [vts_pkg::LIMIT_W-1:0]   x_clamp_limit,
	input  logic [vts_pkg::LIMIT_W-1:0]   y_reject_limit,
	input  logic [vts_pkg::LIMIT_W-1:0]   y_clamp_limit,
	output logic                          out_valid,
	input  logic                          out_ready,
	output vts_pkg::held_t                held_x,
	output vts_pkg::held_t                held_y,
	output logic signed [SUM_W-1:0]       sum_x,
	output logic signed [SUM_W-1:0]       sum_y
);
	import vts_pkg::*;

	// Decode tens, ones and tenths digits; a non-digit byte counts as byte minus '0'.
	function automatic logic signed [DEC_W-1:0] decode_fn(
		logic [CHAR_W-1:0] s,
		logic [CHAR_W-1:0] t,
		logic [CHAR_W-1:0] o,
		logic [CHAR_W-1:0] f
	);
		logic signed [DEC_W-1:0] d_t;
		logic signed [DEC_W-1:0] d_o;
		logic signed [DEC_W-1:0] d_f;
		logic signed [DEC_W-1:0] v;
		d_t = $signed({8'd0, t}) - $signed({8'd0, ASCII_ZERO});
		d_o = $signed({8'd0, o}) - $signed({8'd0, ASCII_ZERO});
		d_f = $signed({8'd0, f}) - $signed({8'd0, ASCII_ZERO});
		v = d_t * 16'sd100 + d_o * 16'sd10 + d_f;
		if (s == ASCII_MINUS) begin
			v = -v;
		end
		return v;
	endfunction

	// Reject values beyond the reject limit, then clamp to the clamp limit.
	function automatic held_t filter_fn(
		logic signed [DEC_W-1:0] v,
		logic [LIMIT_W-1:0]      rej,
		logic [LIMIT_W-1:0]      lim
	);
		logic signed [DEC_W:0] ve;
		logic signed [DEC_W:0] re;
		logic signed [DEC_W:0] ce;
		logic signed [DEC_W:0] nce;
		held_t r;
		ve = {v[DEC_W-1], v};
		re = $signed({7'd0, rej});
		ce = $signed({7'd0, lim});
		nce = -ce;
		if (ve > re || ve < -re) begin
			r = '0;
		end else if (ve > ce) begin
			r = ce[HELD_W-1:0];
		end else if (ve < nce) begin
			r = nce[HELD_W-1:0];
		end else begin
			r = ve[HELD_W-1:0];
		end
		return r;
	endfunction

	logic                    valid_s1;
	logic                    valid_s2;
	logic                    ld_s2;
	cmd_t                    cmd_s1;
	logic signed [DEC_W-1:0] dx_s1;
	logic signed [DEC_W-1:0] dy_s1;
	logic signed [DEC_W-1:0] cand_x;
	logic signed [DEC_W-1:0] cand_y;
	held_t                   fx;
	held_t                   fy;
	held_t                   cur_x_q;
	held_t                   cur_y_q;
	logic signed [SUM_W-1:0] sum_x_q;
	logic signed [SUM_W-1:0] sum_y_q;
	held_t                   win_x_q [WINDOW];
	held_t                   win_y_q [WINDOW];
	logic [HELD_W-1:0]       mag_x;
	logic [HELD_W-1:0]       mag_y;

	// Stage handshake: a stage loads when it is empty or its content moves on.
	assign ld_s2    = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || ld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (!valid_s2 || out_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input register holds the command and the decoded offsets.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd_t'(command);
			dx_s1  <= decode_fn(x_sign_char, x_tens_char, x_ones_char, x_tenths_char);
			dy_s1  <= decode_fn(y_sign_char, y_tens_char, y_ones_char, y_tenths_char);
		end
	end

	// Pick the new, zero or held offset and filter it under the current limits.
	always_comb begin
		case (cmd_s1)
			CMD_GET: begin
				cand_x = dx_s1;
				cand_y = dy_s1;
			end
			CMD_NONE: begin
				cand_x = '0;
				cand_y = '0;
			end
			default: begin
				cand_x = {{(DEC_W - HELD_W){cur_x_q[HELD_W-1]}}, cur_x_q};
				cand_y = {{(DEC_W - HELD_W){cur_y_q[HELD_W-1]}}, cur_y_q};
			end
		endcase
		fx = filter_fn(cand_x, x_reject_limit, x_clamp_limit);
		fy = filter_fn(cand_y, y_reject_limit, y_clamp_limit);
	end

	// Held values, window shift line and running sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			for (int i = 0; i < WINDOW; i++) begin
				win_x_q[i] <= '0;
				win_y_q[i] <= '0;
			end
		end else if (ld_s2) begin
			cur_x_q <= fx;
			cur_y_q <= fy;
			sum_x_q <= sum_x_q + {{(SUM_W - HELD_W){fx[HELD_W-1]}}, fx}
				- {{(SUM_W - HELD_W){win_x_q[WINDOW-1][HELD_W-1]}}, win_x_q[WINDOW-1]};
			sum_y_q <= sum_y_q + {{(SUM_W - HELD_W){fy[HELD_W-1]}}, fy}
				- {{(SUM_W - HELD_W){win_y_q[WINDOW-1][HELD_W-1]}}, win_y_q[WINDOW-1]};
			win_x_q[0] <= fx;
			win_y_q[0] <= fy;
			for (int i = 1; i < WINDOW; i++) begin
				win_x_q[i] <= win_x_q[i-1];
				win_y_q[i] <= win_y_q[i-1];
			end
		end
	end

	assign out_valid = valid_s2;
	assign held_x    = cur_x_q;
	assign held_y    = cur_y_q;
	assign sum_x     = sum_x_q;
	assign sum_y     = sum_y_q;

	// Magnitudes of the held values, for checking against the limits.
	assign mag_x = cur_x_q[HELD_W-1] ? HELD_W'(-cur_x_q) : cur_x_q;
	assign mag_y = cur_y_q[HELD_W-1] ? HELD_W'(-cur_y_q) : cur_y_q;

`ifndef SYNTHESIS
	a_held_within_limits: assert property (@(posedge clk) disable iff (!arst_n)
		ld_s2 |=> (mag_x <= {1'b0, $past(x_clamp_limit)})
			&& (mag_x <= {1'b0, $past(x_reject_limit)})
			&& (mag_y <= {1'b0, $past(y_clamp_limit)})
			&& (mag_y <= {1'b0, $past(y_reject_limit)}))
		else $error("held offset exceeds its limits");
`endif

endmodule

### rtl/vts_mean.sv
module vts_mean #(
	parameter int WINDOW = vts_pkg::WINDOW_DEF,
	localparam int SUM_W = $clog2(WINDOW * vts_pkg::HELD_MAX + 1) + 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  vts_pkg::held_t              held_x,
	input  vts_pkg::held_t              held_y,
	input  logic signed [SUM_W-1:0]     sum_x,
	input  logic signed [SUM_W-1:0]     sum_y,
	input  logic [vts_pkg::GAIN_W-1:0]  steer_gain,
	output logic                        out_valid,
	input  logic                        out_ready,
	output vts_pkg::mean_t              mean
);
	import vts_pkg::*;

	function automatic int gcd_fn(int a, int b);
		int p;
		int q;
		p = a;
		q = b;
		while (p != q) begin
			if (p > q) begin
				p = p - q;
			end else begin
				q = q - p;
			end
		end
		return p;
	endfunction

	// Scale 20/WINDOW reduced to NUM/DEN; division by DEN is a reciprocal multiply.
	localparam int G        = gcd_fn(MEAN_SCALE, WINDOW);
	localparam int NUM      = MEAN_SCALE / G;
	localparam int DEN      = WINDOW / G;
	localparam int NUM_BITS = $clog2(NUM + 1);
	localparam int L        = $clog2(DEN);
	localparam int SUM_MAG  = WINDOW * HELD_MAX;
	localparam int MAG_W    = SUM_W - 1;
	localparam int AX_W     = $clog2(SUM_MAG * GAIN_MAX + 1);
	localparam int AY_W     = $clog2(SUM_MAG * NUM + 1);
	localparam int N_W      = $clog2(SUM_MAG * GAIN_MAX * NUM + 1);
	localparam int SHIFT    = N_W + L;
	localparam int M_W      = N_W + 2;
	localparam int PROD_W   = N_W + M_W;
	localparam int QW       = PROD_W - SHIFT;
	localparam int QE_W     = (QW > SMOOTH_W + 1) ? QW : SMOOTH_W + 1;
	localparam logic [63:0] M_FULL = ((64'd1 << SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN);
	localparam logic [M_W-1:0] M_VAL = M_FULL[M_W-1:0];

	// Apply the sign and saturate to the signed result range.
	function automatic smooth_t sat_fn(logic [QE_W-1:0] q, logic neg);
		logic [QE_W-1:0] nq;
		smooth_t r;
		nq = -q;
		if (!neg) begin
			if (q > QE_W'(2 ** (SMOOTH_W - 1) - 1)) begin
				r = smooth_t'(2 ** (SMOOTH_W - 1) - 1);
			end else begin
				r = q[SMOOTH_W-1:0];
			end
		end else begin
			if (q > QE_W'(2 ** (SMOOTH_W - 1))) begin
				r = {1'b1, {(SMOOTH_W - 1){1'b0}}};
			end else begin
				r = nq[SMOOTH_W-1:0];
			end
		end
		return r;
	endfunction

	logic                       valid_s3;
	logic                       valid_s4;
	logic                       valid_s5;
	logic                       ld_s3;
	logic                       ld_s4;
	logic                       ld_s5;
	logic [MAG_W-1:0]           mag_x;
	logic [MAG_W-1:0]           mag_y;
	logic [MAG_W+GAIN_W-1:0]    ax_full;
	logic [MAG_W+NUM_BITS-1:0]  ay_full;
	logic [AX_W-1:0]            ax_s3;
	logic [AY_W-1:0]            ay_s3;
	logic                       neg_x_s3;
	logic                       neg_y_s3;
	held_t                      hx_s3;
	held_t                      hy_s3;
	logic [AX_W+NUM_BITS-1:0]   nx_full;
	logic [N_W-1:0]             nx_s4;
	logic [N_W-1:0]             ny_s4;
	logic                       neg_x_s4;
	logic                       neg_y_s4;
	held_t                      hx_s4;
	held_t                      hy_s4;
	logic [PROD_W-1:0]          prod_x;
	logic [PROD_W-1:0]          prod_y;
	logic [QE_W-1:0]            qx;
	logic [QE_W-1:0]            qy;
	mean_t                      mean_s5;

	// Stage handshake with bubble removal.
	assign ld_s5    = valid_s4 && (!valid_s5 || out_ready);
	assign ld_s4    = valid_s3 && (!valid_s4 || ld_s5);
	assign ld_s3    = in_valid && in_ready;
	assign in_ready = !valid_s3 || ld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s3 <= in_valid;
			end
			if (!valid_s4 || ld_s5) begin
				valid_s4 <= valid_s3;
			end
			if (!valid_s5 || out_ready) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// Magnitudes of the sums times gain (x) and times the scale numerator (y).
	always_comb begin
		mag_x   = sum_x[SUM_W-1] ? MAG_W'(-sum_x) : MAG_W'(sum_x);
		mag_y   = sum_y[SUM_W-1] ? MAG_W'(-sum_y) : MAG_W'(sum_y);
		ax_full = (MAG_W + GAIN_W)'(mag_x) * (MAG_W + GAIN_W)'(steer_gain);
		ay_full = (MAG_W + NUM_BITS)'(mag_y) * (MAG_W + NUM_BITS)'(NUM);
	end

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			ax_s3    <= ax_full[AX_W-1:0];
			ay_s3    <= ay_full[AY_W-1:0];
			neg_x_s3 <= sum_x[SUM_W-1];
			neg_y_s3 <= sum_y[SUM_W-1];
			hx_s3    <= held_x;
			hy_s3    <= held_y;
		end
	end

	// Scale numerator on x.
	assign nx_full = (AX_W + NUM_BITS)'(ax_s3) * (AX_W + NUM_BITS)'(NUM);

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			nx_s4    <= nx_full[N_W-1:0];
			ny_s4    <= N_W'(ay_s3);
			neg_x_s4 <= neg_x_s3;
			neg_y_s4 <= neg_y_s3;
			hx_s4    <= hx_s3;
			hy_s4    <= hy_s3;
		end
	end

	// Truncating division by DEN through the rounded-up reciprocal.
	always_comb begin
		prod_x = PROD_W'(nx_s4) * PROD_W'(M_VAL);
		prod_y = PROD_W'(ny_s4) * PROD_W'(M_VAL);
		qx     = QE_W'(prod_x[PROD_W-1:SHIFT]);
		qy     = QE_W'(prod_y[PROD_W-1:SHIFT]);
	end

	always_ff @(posedge clk) begin
		if (ld_s5) begin
			mean_s5.held_x   <= hx_s4;
			mean_s5.held_y   <= hy_s4;
			mean_s5.smooth_x <= sat_fn(qx, neg_x_s4);
			mean_s5.smooth_y <= sat_fn(qy, neg_y_s4);
		end
	end

	assign out_valid = valid_s5;
	assign mean      = mean_s5;

`ifndef SYNTHESIS
	a_mean_sign: assert property (@(posedge clk) disable iff (!arst_n)
		ld_s5 |=> ($past(neg_x_s4) ? (mean_s5.smooth_x <= 0) : (mean_s5.smooth_x >= 0))
			&& ($past(neg_y_s4) ? (mean_s5.smooth_y <= 0) : (mean_s5.smooth_y >= 0)))
		else $error("mean sign differs from the window sum sign");
`endif

endmodule

### rtl/vision_target_smoother_top.sv
// Vision target smoother.
// Request channel (in_valid/in_ready): one command with an ASCII frame for x and y.
// A "get" command decodes the frame, "none" zeroes the offsets, others keep them.
// The offsets are filtered, averaged over a WINDOW-deep shift line, and the means
// move the steering targets and, when it stays in its window, the turret angle.
// Result channel (out_valid/out_ready): one result for every request, in order.
// Configuration: cfg_we writes cfg_data into the register chosen by cfg_idx at
// once; the user must write it only while no request is in flight. The block
// itself does not enforce this. The stages in order: decode, filter and sum,
// gain, scale, reciprocal divide, steering.
// Throughput: one request per cycle while the receiver keeps out_ready high;
// every stage holds one request and the gain multiply, the scale multiply and
// the reciprocal multiply each sit in a stage of their own.
// Reset clears the window and sums at once, loads the register defaults and
// sets the turret to 6000. No clearing pass is needed.
// When the receiver stalls, the result register holds and the stages behind it
// keep filling; in_ready falls only once all six stages are occupied.
module vision_target_smoother_top #(
	parameter int WINDOW = vts_pkg::WINDOW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [vts_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [vts_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [vts_pkg::CMD_W-1:0]     command,
	input  logic [vts_pkg::CHAR_W-1:0]    x_sign_char,
	input  logic [vts_pkg::CHAR_W-1:0]    x_tens_char,
	input  logic [vts_pkg::CHAR_W-1:0]    x_ones_char,
	input  logic [vts_pkg::CHAR_W-1:0]    x_tenths_char,
	input  logic [vts_pkg::CHAR_W-1:0]    y_sign_char,
	input  logic [vts_pkg::CHAR_W-1:0]    y_tens_char,
	input  logic [vts_pkg::CHAR_W-1:0]    y_ones_char,
	input  logic [vts_pkg::CHAR_W-1:0]    y_tenths_char,
	output logic                          out_valid,
	input  logic                          out_ready,
	output vts_pkg::held_t                held_x,
	output vts_pkg::held_t                held_y,
	output vts_pkg::smooth_t              smooth_x,
	output vts_pkg::smooth_t              smooth_y,
	output logic signed [vts_pkg::STEER_W-1:0] left_steer_out,
	output logic signed [vts_pkg::STEER_W-1:0] right_steer_out,
	output logic [vts_pkg::TURRET_W-1:0]  turret_out
);
	import vts_pkg::*;

	localparam int SUM_W = $clog2(WINDOW * HELD_MAX + 1) + 1;

	logic [LIMIT_W-1:0]        x_reject_limit_q;
	logic [LIMIT_W-1:0]        x_clamp_limit_q;
	logic [LIMIT_W-1:0]        y_reject_limit_q;
	logic [LIMIT_W-1:0]        y_clamp_limit_q;
	logic [GAIN_W-1:0]         steer_gain_q;
	logic [TURRET_W-1:0]       turret_low_q;
	logic [TURRET_W-1:0]       turret_high_q;

	logic                      trk_valid;
	logic                      trk_ready;
	held_t                     trk_held_x;
	held_t                     trk_held_y;
	logic signed [SUM_W-1:0]   trk_sum_x;
	logic signed [SUM_W-1:0]   trk_sum_y;

	logic                      mean_valid;
	logic                      mean_ready;
	mean_t                     mean;

	logic                      ld_s6;
	logic                      out_valid_q;
	held_t                     held_x_q;
	held_t                     held_y_q;
	smooth_t                   smooth_x_q;
	smooth_t                   smooth_y_q;
	logic signed [STEER_W-1:0] left_steer_q;
	logic signed [STEER_W-1:0] right_steer_q;
	logic [TURRET_W-1:0]       turret_q;
	logic signed [STEER_W-1:0] step_x;
	logic signed [TURRET_W+1:0] turret_cand;
	logic                      turret_move;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_reject_limit_q <= X_REJECT_RST;
			x_clamp_limit_q  <= X_CLAMP_RST;
			y_reject_limit_q <= Y_REJECT_RST;
			y_clamp_limit_q  <= Y_CLAMP_RST;
			steer_gain_q     <= GAIN_RST;
			turret_low_q     <= TURRET_LOW_RST;
			turret_high_q    <= TURRET_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_X_REJECT:    x_reject_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_X_CLAMP:     x_clamp_limit_q  <= cfg_data[LIMIT_W-1:0];
				REG_Y_REJECT:    y_reject_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_Y_CLAMP:     y_clamp_limit_q  <= cfg_data[LIMIT_W-1:0];
				REG_STEER_GAIN:  steer_gain_q     <= cfg_data[GAIN_W-1:0];
				REG_TURRET_LOW:  turret_low_q     <= cfg_data[TURRET_W-1:0];
				REG_TURRET_HIGH: turret_high_q    <= cfg_data[TURRET_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Decode, filter and windowed sums.
	vts_track #(
		.WINDOW(WINDOW)
	) u_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.x_sign_char   (x_sign_char),
		.x_tens_char   (x_tens_char),
		.x_ones_char   (x_ones_char),
		.x_tenths_char (x_tenths_char),
		.y_sign_char   (y_sign_char),
		.y_tens_char   (y_tens_char),
		.y_ones_char   (y_ones_char),
		.y_tenths_char (y_tenths_char),
		.x_reject_limit(x_reject_limit_q),
		.x_clamp_limit (x_clamp_limit_q),
		.y_reject_limit(y_reject_limit_q),
		.y_clamp_limit (y_clamp_limit_q),
		.out_valid     (trk_valid),
		.out_ready     (trk_ready),
		.held_x        (trk_held_x),
		.held_y        (trk_held_y),
		.sum_x         (trk_sum_x),
		.sum_y         (trk_sum_y)
	);

	// Gained and scaled means.
	vts_mean #(
		.WINDOW(WINDOW)
	) u_mean (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (trk_valid),
		.in_ready  (trk_ready),
		.held_x    (trk_held_x),
		.held_y    (trk_held_y),
		.sum_x     (trk_sum_x),
		.sum_y     (trk_sum_y),
		.steer_gain(steer_gain_q),
		.out_valid (mean_valid),
		.out_ready (mean_ready),
		.mean      (mean)
	);

	// Result register takes a new request when empty or being drained.
	assign mean_ready = !out_valid_q || out_ready;
	assign ld_s6      = mean_valid && mean_ready;

	// Steering step and turret candidate from the means.
	always_comb begin
		step_x      = {{(STEER_W - SMOOTH_W){mean.smooth_x[SMOOTH_W-1]}}, mean.smooth_x};
		turret_cand = $signed({2'b00, turret_q})
			+ $signed({{2{mean.smooth_y[SMOOTH_W-1]}}, mean.smooth_y});
		turret_move = (turret_cand > $signed({2'b00, turret_low_q}))
			&& (turret_cand <= $signed({2'b00, turret_high_q}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			left_steer_q  <= '0;
			right_steer_q <= '0;
			turret_q      <= TURRET_RST;
		end else begin
			if (mean_ready) begin
				out_valid_q <= mean_valid;
			end
			if (ld_s6) begin
				left_steer_q  <= left_steer_q - step_x;
				right_steer_q <= right_steer_q + step_x;
				if (turret_move) begin
					turret_q <= turret_cand[TURRET_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s6) begin
			held_x_q   <= mean.held_x;
			held_y_q   <= mean.held_y;
			smooth_x_q <= mean.smooth_x;
			smooth_y_q <= mean.smooth_y;
		end
	end

	assign out_valid       = out_valid_q;
	assign held_x          = held_x_q;
	assign held_y          = held_y_q;
	assign smooth_x        = smooth_x_q;
	assign smooth_y        = smooth_y_q;
	assign left_steer_out  = left_steer_q;
	assign right_steer_out = right_steer_q;
	assign turret_out      = turret_q;

`ifndef SYNTHESIS
	a_steer_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		(left_steer_q + right_steer_q) == '0)
		else $error("left and right steering no longer mirror each other");

	a_turret_window: assert property (@(posedge clk) disable iff (!arst_n)
		ld_s6 |=> (turret_q == $past(turret_q))
			|| ((turret_q > $past(turret_low_q)) && (turret_q <= $past(turret_high_q))))
		else $error("turret moved outside its window");
`endif

endmodule
